[rtl/smfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_pkg
// Shared types, constants and helpers of the SMF track event player.
// ----------------------------------------------------------------------------
package smfp_pkg;

	localparam logic [3:0] PH_DELTA     = 4'd0;
	localparam logic [3:0] PH_STATUS    = 4'd1;
	localparam logic [3:0] PH_DATA1     = 4'd2;
	localparam logic [3:0] PH_DATA2     = 4'd3;
	localparam logic [3:0] PH_META_TYPE = 4'd4;
	localparam logic [3:0] PH_META_LEN  = 4'd5;
	localparam logic [3:0] PH_SYSEX_LEN = 4'd6;
	localparam logic [3:0] PH_SKIP      = 4'd7;

	localparam logic [1:0] KIND_MSG  = 2'd0;
	localparam logic [1:0] KIND_WAIT = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [1:0] REG_DIVISION  = 2'd0;
	localparam logic [1:0] REG_MASTER    = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_DELTA = 2'd1;
	localparam logic [1:0] ACT_MSG   = 2'd2;

	localparam logic [7:0]  META_EOT     = 8'h2F;
	localparam logic [7:0]  META_TEMPO   = 8'h51;
	localparam logic [7:0]  ST_SYSEX     = 8'hF0;
	localparam logic [7:0]  ST_ESCAPE    = 8'hF7;
	localparam logic [7:0]  ST_META      = 8'hFF;
	localparam logic [3:0]  HI_CC        = 4'hB;
	localparam logic [3:0]  HI_PROG      = 4'hC;
	localparam logic [3:0]  HI_PRESS     = 4'hD;
	localparam logic [7:0]  CC_VOLUME    = 8'h07;
	localparam logic [15:0] DELTA_CAP    = 16'd60000;
	localparam logic [23:0] TEMPO_RESET  = 24'd500000;
	localparam logic [6:0]  CHVOL_RESET  = 7'd100;
	localparam logic [6:0]  VOL_MAX      = 7'd127;
	localparam logic [14:0] DIV_RESET    = 15'd96;
	localparam logic [15:0] THR_RESET    = 16'd3000;
	localparam logic [30:0] WAIT_MAX     = 31'h7FFF_FFFF;
	localparam int          PROD_W       = 40;

	typedef struct packed {
		logic capture;
		logic parse;
		logic mul;
		logic div_step;
		logic acc;
		logic load_a;
		logic load_d;
	} smfp_cmd_t;

	typedef struct packed {
		logic done;
		logic go_mul;
		logic have_msg;
		logic new_done;
		logic div_last;
		logic wait_emit;
		logic out_busy;
	} smfp_stat_t;

	// x / 127 for x below 2^14: estimate by 129/2^14, then one correction
	function automatic logic [6:0] div127(input logic [13:0] x);
		logic [21:0] e;
		logic [7:0]  q;
		logic [14:0] r;
		e = {1'b0, x, 7'd0} + {8'd0, x};
		q = e[21:14];
		r = {1'b0, x} - ({q, 7'd0} - {7'd0, q});
		if (r >= 15'd127) q = q + 8'd1;
		return q[6:0];
	endfunction

endpackage

[rtl/smfp_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_in_if
// Track byte request channel.
// ----------------------------------------------------------------------------
interface smfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] track_byte;
	logic       start_of_track;
	logic       last_byte;

	modport source (output valid, track_byte, start_of_track, last_byte, input ready);
	modport sink   (input valid, track_byte, start_of_track, last_byte, output ready);
endinterface

[rtl/smfp_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_out_if
// Result request channel.
// ----------------------------------------------------------------------------
interface smfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  status_byte;
	logic [7:0]  data_one;
	logic [7:0]  data_two;
	logic [30:0] wait_us;
	logic        last_of_run;

	modport source (output valid, result_kind, status_byte, data_one, data_two, wait_us,
		last_of_run, input ready);
	modport sink   (input valid, result_kind, status_byte, data_one, data_two, wait_us,
		last_of_run, output ready);
endinterface

[rtl/smf_track_event_player_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_track_event_player_unit
// Plays one SMF track chunk fed a byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one track byte per request, with start_of_track on the first
//   byte and last_byte on the final one. out_ch carries up to two results per
//   byte: a MIDI message, a wait in microseconds or the end of the track;
//   last_of_run marks the final result of a byte.
//   Registers (division, master volume, merge threshold) are written through
//   cfg_we / cfg_index / cfg_data; the user writes them only while the block is
//   idle, which the block itself does not enforce. Each byte is captured and
//   parsed, then its results are pushed; for a nonzero delta that it completes,
//   delta*tempo is formed before that, divided by the division in the bit-serial
//   divider (one quotient bit per cycle) and added to the pending wait.
//   The input is taken again once all results of a byte are in the output
//   register; a stalled receiver holds the output register and the block.
//   Reset restores register defaults and the empty track state.
// ----------------------------------------------------------------------------
module smf_track_event_player_unit
	import smfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	smfp_in_if.sink           in_ch,
	smfp_out_if.source        out_ch,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	smfp_cmd_t  cmd;
	smfp_stat_t stat;

	smfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	smfp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_byte    (in_ch.track_byte),
		.in_start   (in_ch.start_of_track),
		.in_last    (in_ch.last_byte),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_kind   (out_ch.result_kind),
		.out_status (out_ch.status_byte),
		.out_d1     (out_ch.data_one),
		.out_d2     (out_ch.data_two),
		.out_wait   (out_ch.wait_us),
		.out_last   (out_ch.last_of_run)
	);

endmodule

[rtl/smfp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_datapath
// Parser state, delta-to-microsecond divider, pending wait and output register.
// ----------------------------------------------------------------------------
module smfp_datapath
	import smfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  smfp_cmd_t    cmd,
	output smfp_stat_t   stat,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic [7:0]   in_byte,
	input  logic         in_start,
	input  logic         in_last,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [1:0]   out_kind,
	output logic [7:0]   out_status,
	output logic [7:0]   out_d1,
	output logic [7:0]   out_d2,
	output logic [30:0]  out_wait,
	output logic         out_last
);

	logic [14:0] div_q;
	logic [6:0]  master_q;
	logic [15:0] thr_q;

	logic [7:0]  byte_q;
	logic        last_q;
	logic [3:0]  ph_q;
	logic [7:0]  rs_q, cs_q, fd_q, mt_q;
	logic [27:0] vv_q, sk_q;
	logic [2:0]  vc_q;
	logic [23:0] tc_q, tp_q;
	logic [30:0] pend_q;
	logic        done_q;

	logic [15:0]       dt_q;
	logic [PROD_W-1:0] quo_q;
	logic [14:0]       rem_q;
	logic [5:0]        cnt_q;
	logic [13:0]       vprod_q;

	logic [1:0]  a_kind_q;
	logic [7:0]  a_st_q, a_d1_q, a_d2_q;
	logic [30:0] a_wait_q;
	logic        a_vol_q;

	// parse step
	logic [3:0]  n_ph;
	logic [7:0]  n_rs, n_cs, n_fd, n_mt;
	logic [27:0] n_vv, n_sk, nv, pos, dt;
	logic [2:0]  n_vc, nc;
	logic [23:0] n_tc, n_tp;
	logic        n_done;
	logic [1:0]  act;
	logic [7:0]  m_st, m_d1, m_d2;
	logic [15:0] dtc;
	logic        is_vol;
	logic [6:0]  newvol;
	logic [14:0] div_eff;

	always_comb begin
		n_ph = ph_q; n_rs = rs_q; n_cs = cs_q; n_fd = fd_q; n_mt = mt_q;
		n_vv = vv_q; n_sk = sk_q; n_vc = vc_q; n_tc = tc_q; n_tp = tp_q;
		n_done = done_q;
		act = ACT_NONE; dt = '0; m_st = '0; m_d1 = '0; m_d2 = '0;
		nv = {vv_q[20:0], byte_q[6:0]};
		nc = vc_q + 3'd1;
		pos = vv_q - sk_q;
		case (ph_q)
			PH_DELTA: begin
				n_vv = nv; n_vc = nc;
				if (!byte_q[7] || nc >= 3'd4) begin
					act = ACT_DELTA; dt = nv; n_vv = '0; n_vc = '0; n_ph = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (byte_q[7]) begin
					if (byte_q < ST_SYSEX) n_rs = byte_q;
					n_cs = byte_q; n_vv = '0; n_vc = '0;
					if (byte_q == ST_META) n_ph = PH_META_TYPE;
					else if (byte_q == ST_SYSEX || byte_q == ST_ESCAPE) n_ph = PH_SYSEX_LEN;
					else n_ph = PH_DATA1;
				end else if (rs_q == 8'd0) begin
					n_done = 1'b1;
				end else begin
					n_cs = rs_q; n_fd = byte_q;
					if (rs_q[7:4] == HI_PROG || rs_q[7:4] == HI_PRESS) begin
						act = ACT_MSG; m_st = rs_q; m_d1 = byte_q; n_ph = PH_DELTA;
					end else n_ph = PH_DATA2;
				end
			end
			PH_DATA1: begin
				n_fd = byte_q;
				if (cs_q[7:4] == HI_PROG || cs_q[7:4] == HI_PRESS) begin
					act = ACT_MSG; m_st = cs_q; m_d1 = byte_q; n_ph = PH_DELTA;
				end else n_ph = PH_DATA2;
			end
			PH_DATA2: begin
				act = ACT_MSG; m_st = cs_q; m_d1 = fd_q; m_d2 = byte_q; n_ph = PH_DELTA;
			end
			PH_META_TYPE: begin
				n_mt = byte_q; n_vv = '0; n_vc = '0; n_ph = PH_META_LEN;
			end
			PH_META_LEN, PH_SYSEX_LEN: begin
				n_vv = nv; n_vc = nc;
				if (!byte_q[7] || nc >= 3'd4) begin
					if (ph_q == PH_META_LEN && mt_q == META_EOT) begin
						n_done = 1'b1;
					end else begin
						if (ph_q == PH_SYSEX_LEN) n_mt = 8'd0;
						n_sk = nv; n_tc = '0; n_vc = '0;
						if (nv != 28'd0) n_ph = PH_SKIP;
						else begin
							n_ph = PH_DELTA; n_vv = '0;
						end
					end
				end
			end
			PH_SKIP: begin
				if (mt_q == META_TEMPO && vv_q >= 28'd3 && pos < 28'd3) begin
					n_tc = {tc_q[15:0], byte_q};
					if (pos == 28'd2 && n_tc != 24'd0) n_tp = n_tc;
				end
				n_sk = sk_q - 28'd1;
				if (n_sk == 28'd0) begin
					n_vv = '0; n_vc = '0; n_ph = PH_DELTA;
				end
			end
			default: begin
				n_ph = PH_DELTA; n_vv = '0; n_vc = '0;
			end
		endcase
		if (last_q && !n_done) begin
			if (n_ph == PH_DELTA && n_vc != 3'd0) begin
				act = ACT_DELTA; dt = n_vv; n_vv = '0; n_vc = '0;
			end else if (n_ph == PH_DATA1) begin
				act = ACT_MSG; m_st = n_cs; m_d1 = 8'd0; m_d2 = 8'd0; n_ph = PH_DELTA;
			end else if (n_ph == PH_DATA2) begin
				act = ACT_MSG; m_st = n_cs; m_d1 = n_fd; m_d2 = 8'd0; n_ph = PH_DELTA;
			end
			n_done = 1'b1;
		end
	end

	assign dtc     = (dt > {12'd0, DELTA_CAP}) ? DELTA_CAP : dt[15:0];
	assign is_vol  = (m_st[7:4] == HI_CC) && (m_d1 == CC_VOLUME);
	assign newvol  = m_d2[7] ? VOL_MAX : m_d2[6:0];
	assign div_eff = (div_q == 15'd0) ? DIV_RESET : div_q;

	// divider step and accumulate
	logic [15:0] dtmp;
	logic        dge;
	logic [40:0] sum;
	logic [30:0] sat;
	assign dtmp = {rem_q, quo_q[PROD_W-1]};
	assign dge  = dtmp >= {1'b0, div_eff};
	assign sum  = {10'd0, pend_q} + {1'b0, quo_q};
	assign sat  = (sum > {10'd0, WAIT_MAX}) ? WAIT_MAX : sum[30:0];

	assign stat.done      = done_q;
	assign stat.go_mul    = (act == ACT_DELTA) && (dtc != 16'd0);
	assign stat.have_msg  = (act == ACT_MSG);
	assign stat.new_done  = n_done;
	assign stat.div_last  = (cnt_q == 6'(PROD_W - 1));
	assign stat.wait_emit = (sat >= {15'd0, thr_q});
	assign stat.out_busy  = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= DIV_RESET; master_q <= VOL_MAX; thr_q <= THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIVISION:  div_q <= cfg_data[14:0];
				REG_MASTER:    master_q <= cfg_data[6:0];
				REG_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the current channel volume goes straight to the result, so no per-channel copy is kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_DELTA; rs_q <= '0; cs_q <= '0; fd_q <= '0; mt_q <= '0;
			vv_q <= '0; sk_q <= '0; vc_q <= '0; tc_q <= '0; tp_q <= TEMPO_RESET;
			pend_q <= '0; done_q <= 1'b0;
		end else if (cmd.capture && in_start) begin
			ph_q <= PH_DELTA; rs_q <= '0; cs_q <= '0; fd_q <= '0; mt_q <= '0;
			vv_q <= '0; sk_q <= '0; vc_q <= '0; tc_q <= '0; tp_q <= TEMPO_RESET;
			pend_q <= '0; done_q <= 1'b0;
		end else if (cmd.parse && !done_q) begin
			ph_q <= n_ph; rs_q <= n_rs; cs_q <= n_cs; fd_q <= n_fd; mt_q <= n_mt;
			vv_q <= n_vv; sk_q <= n_sk; vc_q <= n_vc; tc_q <= n_tc; tp_q <= n_tp;
			done_q <= n_done;
		end else if (cmd.acc) begin
			pend_q <= stat.wait_emit ? 31'd0 : sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= in_byte; last_q <= in_last;
		end
		if (cmd.parse) begin
			dt_q     <= dtc;
			vprod_q  <= newvol * master_q;
			a_kind_q <= KIND_MSG;
			a_vol_q  <= is_vol;
			a_st_q   <= is_vol ? {HI_CC, m_st[3:0]} : m_st;
			a_d1_q   <= m_d1;
			a_d2_q   <= m_d2;
			a_wait_q <= '0;
		end
		if (cmd.mul) begin
			quo_q <= PROD_W'(dt_q * tp_q);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[PROD_W-2:0], dge};
			rem_q <= dge ? 15'(dtmp - {1'b0, div_eff}) : dtmp[14:0];
			cnt_q <= cnt_q + 6'd1;
		end
		if (cmd.acc) begin
			a_kind_q <= KIND_WAIT; a_vol_q <= 1'b0;
			a_st_q <= '0; a_d1_q <= '0; a_d2_q <= '0; a_wait_q <= sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.load_a || cmd.load_d) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_a) begin
			out_kind   <= a_kind_q;
			out_status <= a_st_q;
			out_d1     <= a_d1_q;
			out_d2     <= a_vol_q ? {1'b0, div127(vprod_q)} : a_d2_q;
			out_wait   <= a_wait_q;
			out_last   <= !done_q;
		end else if (cmd.load_d) begin
			out_kind <= KIND_END; out_status <= '0; out_d1 <= '0; out_d2 <= '0;
			out_wait <= '0; out_last <= 1'b1;
		end
	end

endmodule

[rtl/smfp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smfp_ctrl
// Sequencer: byte capture, parse, multiply, divide, accumulate, result pushes.
// ----------------------------------------------------------------------------
module smfp_ctrl
	import smfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  smfp_stat_t stat,
	output smfp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PARSE = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_ACC   = 3'd4;
	localparam logic [2:0] S_OUTA  = 3'd5;
	localparam logic [2:0] S_OUTD  = 3'd6;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1; state_d = S_PARSE;
				end
			end
			S_PARSE: begin
				cmd.parse = 1'b1;
				if (stat.done) state_d = S_IDLE;
				else if (stat.go_mul) state_d = S_MUL;
				else if (stat.have_msg) state_d = S_OUTA;
				else if (stat.new_done) state_d = S_OUTD;
				else state_d = S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1; state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (stat.wait_emit) state_d = S_OUTA;
				else if (stat.done) state_d = S_OUTD;
				else state_d = S_IDLE;
			end
			S_OUTA: begin
				if (!stat.out_busy) begin
					cmd.load_a = 1'b1;
					state_d = stat.done ? S_OUTD : S_IDLE;
				end
			end
			S_OUTD: begin
				if (!stat.out_busy) begin
					cmd.load_d = 1'b1; state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for smf_track_event_player_unit.
// Feeds SMF track bytes (directed tracks, then random well-formed tracks with
// noise and truncation), predicts messages, waits and track ends in a local
// parser model, and compares every result request field by field. Both
// channels stall at random; registers change between drained phases.
// ----------------------------------------------------------------------------
module tb;
	import smfp_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       sot;
		logic       lst;
	} track_item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  st;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [30:0] w;
		logic        lst;
	} player_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	smfp_in_if  in_ch();
	smfp_out_if out_ch();

	smf_track_event_player_unit uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	track_item_t    byte_q[$];
	player_result_t expected_q[$];
	logic [7:0]     trk_q[$];
	int errors = 0;

	// model of the player
	logic [14:0] m_div;
	logic [6:0]  m_mvol;
	logic [15:0] m_thr;
	logic [3:0]  m_phase;
	logic [7:0]  m_rs, m_cs, m_fd, m_mtype;
	logic [27:0] m_vlq, m_skip;
	logic [2:0]  m_vcnt;
	logic [23:0] m_tcol, m_tempo;
	logic [30:0] m_pend;
	logic [6:0]  m_chvol[16];
	logic        m_done;

	task automatic track_restart();
		m_phase = PH_DELTA;
		m_rs = 0; m_cs = 0; m_fd = 0; m_vlq = 0; m_vcnt = 0; m_mtype = 0;
		m_skip = 0; m_tcol = 0; m_tempo = TEMPO_RESET; m_pend = 0; m_done = 0;
		for (int i = 0; i < 16; i++) m_chvol[i] = CHVOL_RESET;
	endtask

	task automatic add_result(logic [1:0] kind, logic [7:0] st, logic [7:0] d1,
		logic [7:0] d2, logic [30:0] w);
		expected_q.push_back('{kind, st, d1, d2, w, 1'b0});
	endtask

	task automatic close_delta();
		longint unsigned dt, d, wt, s;
		dt = m_vlq;
		m_vlq = 0;
		m_vcnt = 0;
		if (dt > 60000) dt = 60000;
		if (dt == 0) return;
		d = (m_div != 0) ? m_div : 96;
		wt = dt * (m_tempo / d) + (dt * (m_tempo % d)) / d;
		s = m_pend + wt;
		m_pend = (s > WAIT_MAX) ? WAIT_MAX : s[30:0];
		if (m_pend < m_thr) return;
		add_result(KIND_WAIT, 0, 0, 0, m_pend);
		m_pend = 0;
	endtask

	task automatic send_msg(logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
		int unsigned v;
		if (st[7:4] == HI_CC && d1 == CC_VOLUME) begin
			m_chvol[st[3:0]] = (d2 > 127) ? VOL_MAX : d2[6:0];
			v = m_chvol[st[3:0]] * m_mvol / 127;
			add_result(KIND_MSG, {HI_CC, st[3:0]}, CC_VOLUME, v[7:0], 0);
		end else begin
			add_result(KIND_MSG, st, d1, d2, 0);
		end
		m_phase = PH_DELTA;
	endtask

	function automatic bit vlq_add(logic [7:0] b);
		m_vlq = {m_vlq[20:0], b[6:0]};
		m_vcnt++;
		return !b[7] || m_vcnt >= 4;
	endfunction

	task automatic begin_skip();
		m_skip = m_vlq;
		m_tcol = 0;
		m_vcnt = 0;
		m_phase = (m_skip != 0) ? PH_SKIP : PH_DELTA;
		if (m_phase == PH_DELTA) m_vlq = 0;
	endtask

	function automatic bit single_data(logic [7:0] st);
		return st[7:4] == HI_PROG || st[7:4] == HI_PRESS;
	endfunction

	task automatic predict_byte(logic [7:0] b, logic sot, logic lst);
		int n0;
		logic [27:0] pos;
		n0 = expected_q.size();
		if (sot) track_restart();
		if (m_done) return;
		case (m_phase)
			PH_DELTA: begin
				if (vlq_add(b)) begin
					close_delta();
					m_phase = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (b[7]) begin
					if (b < ST_SYSEX) m_rs = b;
					m_cs = b;
					m_vlq = 0;
					m_vcnt = 0;
					if (b == ST_META) m_phase = PH_META_TYPE;
					else if (b == ST_SYSEX || b == ST_ESCAPE) m_phase = PH_SYSEX_LEN;
					else m_phase = PH_DATA1;
				end else if (m_rs == 0) begin
					m_done = 1;
				end else begin
					m_cs = m_rs;
					m_fd = b;
					if (single_data(m_cs)) send_msg(m_cs, b, 0);
					else m_phase = PH_DATA2;
				end
			end
			PH_DATA1: begin
				m_fd = b;
				if (single_data(m_cs)) send_msg(m_cs, b, 0);
				else m_phase = PH_DATA2;
			end
			PH_DATA2: send_msg(m_cs, m_fd, b);
			PH_META_TYPE: begin
				m_mtype = b;
				m_vlq = 0;
				m_vcnt = 0;
				m_phase = PH_META_LEN;
			end
			PH_META_LEN: begin
				if (vlq_add(b)) begin
					if (m_mtype == META_EOT) m_done = 1;
					else begin_skip();
				end
			end
			PH_SYSEX_LEN: begin
				if (vlq_add(b)) begin
					m_mtype = 0;
					begin_skip();
				end
			end
			PH_SKIP: begin
				pos = m_vlq - m_skip;
				if (m_mtype == META_TEMPO && m_vlq >= 3 && pos < 3) begin
					m_tcol = {m_tcol[15:0], b};
					if (pos == 2 && m_tcol != 0) m_tempo = m_tcol;
				end
				m_skip--;
				if (m_skip == 0) begin
					m_vlq = 0;
					m_vcnt = 0;
					m_phase = PH_DELTA;
				end
			end
			default: begin
				m_phase = PH_DELTA;
				m_vlq = 0;
				m_vcnt = 0;
			end
		endcase
		if (lst && !m_done) begin
			if (m_phase == PH_DELTA && m_vcnt != 0) close_delta();
			else if (m_phase == PH_DATA1) send_msg(m_cs, 0, 0);
			else if (m_phase == PH_DATA2) send_msg(m_cs, m_fd, 0);
			m_done = 1;
		end
		if (m_done) add_result(KIND_END, 0, 0, 0, 0);
		if (expected_q.size() > n0) expected_q[expected_q.size() - 1].lst = 1'b1;
	endtask

	// stimulus building
	logic [7:0] gen_rs;

	task automatic queue_track(bit with_last);
		for (int i = 0; i < trk_q.size(); i++)
			byte_q.push_back('{trk_q[i], i == 0, with_last && i == trk_q.size() - 1});
		trk_q.delete();
	endtask

	task automatic add_vlq(int unsigned v);
		int n;
		n = (v < 128) ? 1 : (v < 16384) ? 2 : (v < 2097152) ? 3 : 4;
		for (int i = n - 1; i >= 0; i--)
			trk_q.push_back(((v >> (7 * i)) & 8'h7F) | ((i != 0) ? 8'h80 : 8'h00));
	endtask

	function automatic logic [7:0] data_val();
		return ($urandom_range(0, 99) < 90) ? $urandom_range(0, 127) : $urandom_range(0, 255);
	endfunction

	task automatic add_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) add_vlq(0);
		else if (r < 65) add_vlq($urandom_range(1, 127));
		else if (r < 85) add_vlq($urandom_range(128, 16383));
		else if (r < 95) add_vlq($urandom_range(16384, 268435455));
		else repeat (4) trk_q.push_back($urandom_range(128, 255));
	endtask

	task automatic add_event();
		int r, len;
		logic [7:0] st;
		logic [23:0] tmp;
		r = $urandom_range(0, 79);
		if (r < 40) begin
			if (gen_rs != 0 && $urandom_range(0, 1)) begin
				st = gen_rs;
			end else begin
				st = $urandom_range(8'h80, 8'hEF);
				gen_rs = st;
				trk_q.push_back(st);
			end
			trk_q.push_back(data_val());
			if (!single_data(st)) trk_q.push_back(data_val());
		end else if (r < 50) begin
			st = {HI_CC, 4'($urandom_range(0, 15))};
			gen_rs = st;
			trk_q.push_back(st);
			trk_q.push_back(CC_VOLUME);
			trk_q.push_back($urandom_range(0, 255));
		end else if (r < 58) begin
			len = ($urandom_range(0, 3) != 0) ? 3 : $urandom_range(0, 5);
			tmp = ($urandom_range(0, 9) == 0) ? 24'd0 : $urandom_range(1, 24'hFFFFFF);
			trk_q.push_back(ST_META);
			trk_q.push_back(META_TEMPO);
			trk_q.push_back(len);
			for (int i = 0; i < len; i++)
				trk_q.push_back((i < 3) ? tmp[23 - 8 * i -: 8] : data_val());
		end else if (r < 65) begin
			len = $urandom_range(0, 4);
			trk_q.push_back(ST_META);
			trk_q.push_back($urandom_range(0, 255));
			trk_q.push_back(len);
			repeat (len) trk_q.push_back($urandom_range(0, 255));
		end else if (r < 71) begin
			len = $urandom_range(0, 5);
			trk_q.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_ESCAPE);
			add_vlq(len);
			repeat (len) trk_q.push_back($urandom_range(0, 255));
		end else if (r < 76) begin
			do st = $urandom_range(8'hF1, 8'hFE); while (st == ST_ESCAPE);
			trk_q.push_back(st);
			trk_q.push_back(data_val());
			trk_q.push_back(data_val());
		end else begin
			trk_q.push_back($urandom_range(0, 255));
		end
	endtask

	task automatic random_track();
		int cut;
		gen_rs = 0;
		repeat ($urandom_range(2, 12)) begin
			add_delta();
			add_event();
		end
		if ($urandom_range(0, 1)) begin
			trk_q.push_back(0);
			trk_q.push_back(ST_META);
			trk_q.push_back(META_EOT);
			trk_q.push_back(0);
			repeat ($urandom_range(0, 2)) trk_q.push_back($urandom_range(0, 255));
			queue_track($urandom_range(0, 3) != 0);
		end else begin
			cut = $urandom_range(trk_q.size() / 2, trk_q.size() - 1);
			while (trk_q.size() > cut + 1) void'(trk_q.pop_back());
			queue_track(1);
		end
	endtask

	task automatic directed_tracks();
		// note, running status, program change, volume above 127, tempo set,
		// zero tempo, sysex, system message, empty meta, 4-byte delta, end meta
		trk_q = '{8'h00, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h3C, 8'h00, 8'h60, 8'hC0, 8'h05,
			8'h81, 8'h00, 8'hB3, 8'h07, 8'hC8, 8'h00, 8'hFF, 8'h51, 8'h03, 8'h0F,
			8'h42, 8'h40, 8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00,
			8'h00, 8'hF0, 8'h02, 8'hFF, 8'h80, 8'h00, 8'hF1, 8'hAA, 8'hBB,
			8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hE2, 8'h01,
			8'h02, 8'h00, 8'hFF, 8'h2F, 8'h00, 8'h90};
		queue_track(0);
		// data byte with no running status
		trk_q = '{8'h00, 8'h40, 8'h11};
		queue_track(0);
		// last byte mid-delta, mid-message on first and second data byte
		trk_q = '{8'h00, 8'h90, 8'h01, 8'h02, 8'h83};
		queue_track(1);
		trk_q = '{8'h00, 8'h90};
		queue_track(1);
		trk_q = '{8'h00, 8'hA1, 8'h3C};
		queue_track(1);
	endtask

	// sender
	logic in_taken = 1'b0, out_taken = 1'b0;
	int src_gap = 0, snk_stall = 0;
	bit src_burst = 0, snk_burst = 0;
	bit long_hold_req = 0;

	function automatic int draw_gap(ref bit burst);
		if ($urandom_range(0, 39) == 0) burst = !burst;
		return burst ? 0 : $urandom_range(0, 12);
	endfunction

	always @(negedge clk) begin
		track_item_t it;
		if (arst_n) begin
			if (in_ch.valid && !in_taken) begin
			end else if (src_gap > 0) begin
				src_gap--;
				in_ch.valid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				it = byte_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.track_byte <= it.b;
				in_ch.start_of_track <= it.sot;
				in_ch.last_byte <= it.lst;
				src_gap = draw_gap(src_burst);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) snk_stall = draw_gap(snk_burst);
			if (long_hold_req) begin
				snk_stall = 400;
				long_hold_req = 0;
			end
			if (snk_stall > 0) begin
				snk_stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// monitor, model update and watchdog
	int idle_cycles = 0;

	always @(posedge clk) begin
		player_result_t e;
		in_taken <= in_ch.valid && in_ch.ready;
		out_taken <= out_ch.valid && out_ch.ready;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				predict_byte(in_ch.track_byte, in_ch.start_of_track, in_ch.last_byte);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result kind %0h", out_ch.result_kind);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (out_ch.result_kind !== e.kind) begin
						$error("result_kind exp %0h got %0h", e.kind, out_ch.result_kind);
						errors++;
					end
					if (out_ch.status_byte !== e.st) begin
						$error("status_byte exp %0h got %0h", e.st, out_ch.status_byte);
						errors++;
					end
					if (out_ch.data_one !== e.d1) begin
						$error("data_one exp %0h got %0h", e.d1, out_ch.data_one);
						errors++;
					end
					if (out_ch.data_two !== e.d2) begin
						$error("data_two exp %0h got %0h", e.d2, out_ch.data_two);
						errors++;
					end
					if (out_ch.wait_us !== e.w) begin
						$error("wait_us exp %0d got %0d", e.w, out_ch.wait_us);
						errors++;
					end
					if (out_ch.last_of_run !== e.lst) begin
						$error("last_of_run exp %0b got %0b", e.lst, out_ch.last_of_run);
						errors++;
					end
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > 20000) begin
				$display("[smf_track_event_player_unit] ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_DIVISION) m_div = val[14:0];
		else if (idx == REG_MASTER) m_mvol = val[6:0];
		else m_thr = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		while (byte_q.size() != 0 || in_ch.valid || expected_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic run_phase(int nbytes);
		int start;
		start = byte_q.size();
		while (byte_q.size() - start < nbytes) random_track();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.track_byte = 0;
		in_ch.start_of_track = 1'b0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIVISION;
		cfg_data = 0;
		m_div = DIV_RESET;
		m_mvol = VOL_MAX;
		m_thr = THR_RESET;
		track_restart();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_tracks();
		run_phase(300);
		drain();

		write_reg(REG_DIVISION, 1);
		write_reg(REG_MASTER, 0);
		write_reg(REG_THRESHOLD, 0);
		directed_tracks();
		run_phase(320);
		long_hold_req = 1;
		drain();

		write_reg(REG_DIVISION, 16'h7FFF);
		write_reg(REG_MASTER, 127);
		write_reg(REG_THRESHOLD, 16'hFFFF);
		run_phase(330);
		drain();

		// division of zero falls back to the default
		write_reg(REG_DIVISION, 0);
		write_reg(REG_MASTER, 64);
		write_reg(REG_THRESHOLD, 1);
		run_phase(330);
		drain();

		write_reg(REG_DIVISION, $urandom_range(1, 32767));
		write_reg(REG_MASTER, $urandom_range(0, 127));
		write_reg(REG_THRESHOLD, $urandom_range(0, 65535));
		run_phase(330);
		drain();

		repeat (100) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("[smf_track_event_player_unit] OK");
		else
			$display("[smf_track_event_player_unit] ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/smfp_pkg.sv
rtl/smfp_in_if.sv
rtl/smfp_out_if.sv
rtl/smfp_datapath.sv
rtl/smfp_ctrl.sv
rtl/smf_track_event_player_unit.sv
tb/tb.sv
